@@ src/assert_macros.svh @@
// Assertion helpers shared by the RTL.
// Checks compile in unless SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Expression must hold at every clock edge outside reset.
`define LPD_ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Antecedent in a cycle implies consequent in the next cycle.
`define LPD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define LPD_ASSERT_ALWAYS(lbl, clk, rst, expr, msg)

`define LPD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

@@ src/lpd_pkg.sv @@
package lpd_pkg;

   localparam int LEN_W = 31;

   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_EMPTY   = 2'd2;

   localparam logic [7:0] LONG_FORM_BIT = 8'h80;
   localparam logic [7:0] LONG_HI_MASK  = 8'h7F;
   localparam logic [3:0] HEX_ALPHA_OFS = 4'd10;

   localparam logic [1:0] LAST_HDR_IDX = 2'd3;

   typedef struct packed {
      logic [7:0] stream_byte;
      logic       chunk_last;
   } req_beat_type;

   typedef struct packed {
      logic [1:0]       byte_kind;
      logic [7:0]       payload_byte;
      logic             first_of_packet;
      logic             last_of_packet;
      logic [LEN_W-1:0] packet_length;
      logic             chunk_end;
   } rsp_beat_type;

   // Parser state visible to the top level for checking.
   typedef struct packed {
      logic       in_payload;
      logic [1:0] header_count;
   } parse_status_type;

   // ASCII hex digit; anything else reads as zero.
   function automatic logic [3:0] hex_digit(input logic [7:0] ch);
      logic [3:0] d;
      d = 4'd0;
      if (ch inside {[8'h30:8'h39]}) begin
         d = ch[3:0];
      end else if (ch inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
         d = 4'(ch[2:0] - 3'd1) + HEX_ALPHA_OFS;
      end
      return d;
   endfunction

   function automatic logic [LEN_W-1:0] decode_length(input logic [7:0] b0,
                                                      input logic [7:0] b1,
                                                      input logic [7:0] b2,
                                                      input logic [7:0] b3);
      logic [LEN_W-1:0] len;
      logic [7:0]       hi;
      hi = b0 & LONG_HI_MASK;
      if ((b0 & LONG_FORM_BIT) != 8'd0) begin
         len = {hi[6:0], b1, b2, b3};
      end else begin
         len = LEN_W'({hex_digit(b0), hex_digit(b1), hex_digit(b2), hex_digit(b3)});
      end
      return len;
   endfunction

endpackage

@@ src/lpd_chan_if.sv @@
interface lpd_chan_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);

endinterface

@@ src/lpd_in_reg.sv @@
// Input register: one beat of storage in front of the parser.
module lpd_in_reg (
   input  logic                 clock,
   input  logic                 reset,
   lpd_chan_if.sink             req_chan,
   input  logic                 take,
   output logic                 in_valid,
   output lpd_pkg::req_beat_type in_beat
);

   logic                  valid_ff;
   logic                  valid_in;
   lpd_pkg::req_beat_type beat_ff;
   logic                  accept;

   assign req_chan.ready = !valid_ff || take;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         beat_ff <= req_chan.payload;
      end
   end

   assign in_valid = valid_ff;
   assign in_beat  = beat_ff;

endmodule

@@ src/lpd_parse.sv @@
// Header/payload parser with its result register.
module lpd_parse (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  lpd_pkg::req_beat_type     in_beat,
   output logic                      take,
   output lpd_pkg::parse_status_type status,
   lpd_chan_if.source                rsp_chan
);

   localparam int LW = lpd_pkg::LEN_W;

   logic [23:0]   store_ff, store_in;
   logic [1:0]    count_ff, count_in;
   logic          in_pay_ff, in_pay_in;
   logic [LW-1:0] left_ff, left_in;
   logic          seen_ff, seen_in;
   logic [LW-1:0] cur_len_ff, cur_len_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   lpd_pkg::rsp_beat_type  rsp_ff, rsp_in;
   logic [LW-1:0]          len;
   logic                   last;

   assign take = in_valid && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      store_in   = store_ff;
      count_in   = count_ff;
      in_pay_in  = in_pay_ff;
      left_in    = left_ff;
      seen_in    = seen_ff;
      cur_len_in = cur_len_ff;
      last       = (left_ff <= LW'(1));
      len        = lpd_pkg::decode_length(store_ff[23:16], store_ff[15:8], store_ff[7:0],
                                          in_beat.stream_byte);

      rsp_in.byte_kind       = lpd_pkg::KIND_HEADER;
      rsp_in.payload_byte    = 8'd0;
      rsp_in.first_of_packet = 1'b0;
      rsp_in.last_of_packet  = 1'b0;
      rsp_in.packet_length   = '0;
      rsp_in.chunk_end       = in_beat.chunk_last;

      if (in_pay_ff) begin
         rsp_in.byte_kind       = lpd_pkg::KIND_PAYLOAD;
         rsp_in.payload_byte    = in_beat.stream_byte;
         rsp_in.first_of_packet = !seen_ff;
         rsp_in.last_of_packet  = last;
         rsp_in.packet_length   = cur_len_ff;
         seen_in = 1'b1;
         left_in = left_ff - LW'(1);
         if (last) begin
            in_pay_in = 1'b0;
            left_in   = '0;
            seen_in   = 1'b0;
            count_in  = 2'd0;
         end
      end else if (count_ff != lpd_pkg::LAST_HDR_IDX) begin
         store_in = {store_ff[15:0], in_beat.stream_byte};
         count_in = count_ff + 2'd1;
      end else begin
         count_in   = 2'd0;
         store_in   = '0;
         cur_len_in = len;
         rsp_in.packet_length = len;
         if (len == '0) begin
            rsp_in.byte_kind       = lpd_pkg::KIND_EMPTY;
            rsp_in.first_of_packet = 1'b1;
            rsp_in.last_of_packet  = 1'b1;
         end else begin
            in_pay_in = 1'b1;
            left_in   = len;
            seen_in   = 1'b0;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         store_ff     <= '0;
         count_ff     <= 2'd0;
         in_pay_ff    <= 1'b0;
         left_ff      <= '0;
         seen_ff      <= 1'b0;
         cur_len_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            store_ff   <= store_in;
            count_ff   <= count_in;
            in_pay_ff  <= in_pay_in;
            left_ff    <= left_in;
            seen_ff    <= seen_in;
            cur_len_ff <= cur_len_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   assign status.in_payload   = in_pay_ff;
   assign status.header_count = count_ff;

endmodule

@@ src/length_prefixed_deframer_unit.sv @@
// Length-prefixed deframer. Takes a raw byte stream made of packets, each a
// 4-byte length header followed by that many payload bytes, and returns one
// result beat per input beat: header byte consumed, payload byte (with
// first/last-of-packet marks and the packet length), or empty packet done.
// A header whose first byte has bit 7 set is a 31-bit big-endian length;
// otherwise the four bytes are ASCII hex digits, most significant first, and
// non-hex characters count as zero. The chunk_last flag is echoed as
// chunk_end and never affects parsing. Throughput is one beat per clock
// while rsp_chan is ready. Each beat passes the input register, then parse
// logic into the result register. Parser state advances only when a beat
// moves into the result register, so rsp_chan stalls back up into req_chan.
`include "assert_macros.svh"

module length_prefixed_deframer_unit (
   input  logic      clock,
   input  logic      reset,
   lpd_chan_if.sink   req_chan,
   lpd_chan_if.source rsp_chan
);

   // Input stage -> parser hand-off.
   logic                      in_valid;
   lpd_pkg::req_beat_type     in_beat;
   logic                      take;
   lpd_pkg::parse_status_type status;

   // Input register: holds one beat, refilled in the cycle it drains.
   lpd_in_reg u_in_reg (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .take     (take),
      .in_valid (in_valid),
      .in_beat  (in_beat)
   );

   // Parser: header shift/decode, payload countdown, result register.
   lpd_parse u_parse (
      .clock    (clock),
      .reset    (reset),
      .in_valid (in_valid),
      .in_beat  (in_beat),
      .take     (take),
      .status   (status),
      .rsp_chan (rsp_chan)
   );

   // Every accepted beat lands in the input register.
   `LPD_ASSERT_NEXT(a_accept_lands, clock, reset, req_chan.valid && req_chan.ready, in_valid, "accepted beat lost")

   // Header count is cleared for the whole payload phase.
   `LPD_ASSERT_ALWAYS(a_count_clear, clock, reset, !status.in_payload || (status.header_count == 2'd0), "header count nonzero in payload")

   // Empty packet carries both marks and zero length.
   `LPD_ASSERT_ALWAYS(a_empty_marks, clock, reset, !(rsp_chan.valid && (rsp_chan.payload.byte_kind == lpd_pkg::KIND_EMPTY)) || (rsp_chan.payload.first_of_packet && rsp_chan.payload.last_of_packet && (rsp_chan.payload.packet_length == '0)), "bad empty packet")

   // Payload byte is zero unless the beat is payload.
   `LPD_ASSERT_ALWAYS(a_pbyte_zero, clock, reset, !(rsp_chan.valid && (rsp_chan.payload.byte_kind != lpd_pkg::KIND_PAYLOAD)) || (rsp_chan.payload.payload_byte == 8'd0), "payload byte on non-payload beat")

endmodule
